// ----- design/rbd_pkg.sv -----
// Shared types, codes and defaults for the run-length back-reference decoder.
`timescale 1ns / 1ps

package rbd_pkg;

    // Defaults for the top-level parameters
    localparam int HISTORY_DEPTH_DEF = 65536;
    localparam int MAX_DIM_DEF       = 1024;
    localparam int LANES_DEF         = 4;

    // Fixed widths of the ports
    localparam int BYTE_W     = 8;
    localparam int REG_W      = 11;
    localparam int COUNT_W    = 3;
    localparam int LANE_SLOTS = 4;

    // Command opcodes
    localparam logic [BYTE_W-1:0] OP_FILL_N = 8'h00;
    localparam logic [BYTE_W-1:0] OP_LIT_N  = 8'h80;
    localparam logic [BYTE_W-1:0] OP_BACK   = 8'h40;
    localparam logic [BYTE_W-1:0] OP_FILL_B = 8'hC0;

    // Configuration register indexes
    typedef enum logic [0:0] {
        CFG_IMAGE_WIDTH  = 1'b0,
        CFG_IMAGE_HEIGHT = 1'b1
    } t_cfg_idx;

    // Command parser position
    typedef enum logic [2:0] {
        PH_OPCODE   = 3'd0,
        PH_VALUE    = 3'd1,
        PH_COUNT    = 3'd2,
        PH_LITERAL  = 3'd3,
        PH_OFFHI    = 3'd4,
        PH_FILLBYTE = 3'd5
    } t_phase;

    // Sequencer state
    typedef enum logic [2:0] {
        ST_IDLE    = 3'd0,
        ST_EXEC    = 3'd1,
        ST_FILL    = 3'd2,
        ST_COPY_RD = 3'd3,
        ST_COPY_WR = 3'd4,
        ST_FINAL   = 3'd5
    } t_state;

endpackage

// ----- design/rbd_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module rbd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- design/rle_backref_decompressor.sv -----
// Top level of the run-length decoder with back references into the output history.
//
// Usage:
//   Source channel (i_src_valid / o_src_ready) takes one compressed byte per request,
//   with i_src_last on the final byte of the stream. Pixel channel
//   (o_pix_valid / i_pix_ready) returns results of up to four decoded bytes
//   (fewer when LANES is below four), with run_last on the last result caused by a
//   source byte and finished/status on the result that ends decoding.
//   Configuration: i_cfg_wr_en writes i_cfg_wdata to image_width (index 0) or
//   image_height (index 1); write only while the block is idle.
// Sequencing:
//   A source byte is taken in the idle state, parsed in the next cycle, and a
//   closing state pushes the final result of that byte, if it has one. Fill runs
//   emit one byte per cycle while the lane buffer has room; back copies emit each
//   byte as a history RAM read, then a write. Both go through the single
//   byte-emit path, and each full result is pushed in a step of its own.
// Reset and stall:
//   Reset returns the parser to the opcode phase, clears the output count and the
//   done flag and sets both dimensions to 1; the history RAM is not cleared, since
//   each entry is read only after it was written. A stalled receiver holds the
//   result register and the sequencer waits before the next push; the next source
//   byte can still be taken while the final result of the previous one is waiting.
`timescale 1ns / 1ps

module rle_backref_decompressor #(
    parameter int HISTORY_DEPTH = rbd_pkg::HISTORY_DEPTH_DEF,
    parameter int MAX_DIM       = rbd_pkg::MAX_DIM_DEF,
    parameter int LANES         = rbd_pkg::LANES_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // configuration
    input  logic                         i_cfg_wr_en,
    input  rbd_pkg::t_cfg_idx            i_cfg_index,
    input  logic [rbd_pkg::REG_W-1:0]    i_cfg_wdata,
    // source channel
    input  logic                         i_src_valid,
    output logic                         o_src_ready,
    input  logic [rbd_pkg::BYTE_W-1:0]   i_src_byte,
    input  logic                         i_src_last,
    // pixel channel
    output logic                         o_pix_valid,
    input  logic                         i_pix_ready,
    output logic [rbd_pkg::BYTE_W-1:0]   o_pixel_0,
    output logic [rbd_pkg::BYTE_W-1:0]   o_pixel_1,
    output logic [rbd_pkg::BYTE_W-1:0]   o_pixel_2,
    output logic [rbd_pkg::BYTE_W-1:0]   o_pixel_3,
    output logic [rbd_pkg::COUNT_W-1:0]  o_pixel_count,
    output logic                         o_run_last,
    output logic                         o_finished,
    output logic                         o_status
);

    import rbd_pkg::*;

    // Address width of the history RAM, width of the dimensions and width of the output byte counter
    localparam int AW    = $clog2(HISTORY_DEPTH);
    localparam int DIM_W = ($clog2(MAX_DIM + 1) > REG_W) ? $clog2(MAX_DIM + 1) : REG_W;
    localparam int CNT_W = $clog2(MAX_DIM * MAX_DIM + 1);
    // Width for offset compares and read-pointer arithmetic
    localparam int EW    = (CNT_W > 18) ? CNT_W : 18;
    localparam logic [COUNT_W-1:0] LANE_LIM =
        COUNT_W'((LANES > LANE_SLOTS) ? LANE_SLOTS : LANES);
    localparam logic [AW-1:0] PTR_LAST = AW'(HISTORY_DEPTH - 1);

    // Dimension clamp: zero counts as one, anything above MAX_DIM as MAX_DIM
    function automatic logic [DIM_W-1:0] clamp_dim(input logic [REG_W-1:0] v);
        logic [DIM_W-1:0] vx;
        vx = DIM_W'(v);
        if (vx == '0) begin
            return DIM_W'(1);
        end else if (vx > DIM_W'(MAX_DIM)) begin
            return DIM_W'(MAX_DIM);
        end
        return vx;
    endfunction

    // Configuration and output-size target
    logic [REG_W-1:0]   r_width, r_height;
    logic [2*DIM_W-1:0] size_prod;
    logic [CNT_W-1:0]   r_target;

    // Sequencer and parser state
    t_state             r_state, n_state;
    t_phase             r_phase, n_phase;
    logic [BYTE_W-1:0]  r_op, n_op;
    logic [BYTE_W-1:0]  r_val, n_val;
    logic [BYTE_W-1:0]  r_lit_left, n_lit_left;
    logic [CNT_W-1:0]   r_bw, n_bw;
    logic [AW-1:0]      r_wptr, n_wptr;
    logic [AW-1:0]      r_rptr, n_rptr;
    logic [BYTE_W-1:0]  r_run_left, n_run_left;
    logic [BYTE_W-1:0]  r_fill_byte, n_fill_byte;
    logic               r_done, n_done;
    logic               r_bad, n_bad;
    logic [BYTE_W-1:0]  r_byte, n_byte;
    logic               r_last, n_last;

    // Lane buffer that collects bytes for the next result
    logic [BYTE_W-1:0]  r_lane [LANE_SLOTS];
    logic [BYTE_W-1:0]  n_lane [LANE_SLOTS];
    logic [COUNT_W-1:0] r_fill, n_fill;

    // Result register
    logic               r_out_valid, n_out_valid;
    logic [BYTE_W-1:0]  r_pix [LANE_SLOTS];
    logic [BYTE_W-1:0]  n_pix [LANE_SLOTS];
    logic [COUNT_W-1:0] r_cnt, n_cnt;
    logic               r_run_last, n_run_last;
    logic               r_finished, n_finished;
    logic               r_status, n_status;

    // Shared byte-emit path and history RAM port signals
    logic               emit_en;
    logic [BYTE_W-1:0]  emit_byte;
    logic               mem_re;
    logic [BYTE_W-1:0]  mem_rdata;

    logic               slot_free;
    logic               at_target;
    logic               fin, fail;
    logic [EW-1:0]      off_x, bw_x, wptr_x, rptr_x;
    logic               off_bad;

    // ---------------------------------------------------------------------
    // Configuration registers; the target is registered in the cycle after a
    // dimension write, before a byte taken after that write reaches the parse step
    // ---------------------------------------------------------------------
    assign size_prod = (2*DIM_W)'(clamp_dim(r_width)) * (2*DIM_W)'(clamp_dim(r_height));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= REG_W'(1);
            r_height <= REG_W'(1);
            r_target <= CNT_W'(1);
        end else begin
            if (i_cfg_wr_en) begin
                unique case (i_cfg_index)
                    CFG_IMAGE_WIDTH:  r_width  <= i_cfg_wdata;
                    CFG_IMAGE_HEIGHT: r_height <= i_cfg_wdata;
                endcase
            end
            r_target <= size_prod[CNT_W-1:0];
        end
    end

    // ---------------------------------------------------------------------
    // History RAM: written by every emitted byte, read by back copies
    // ---------------------------------------------------------------------
    rbd_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (HISTORY_DEPTH)
    ) u_hist (
        .i_clk   (i_clk),
        .i_we    (emit_en),
        .i_waddr (r_wptr),
        .i_wdata (emit_byte),
        .i_re    (mem_re),
        .i_raddr (r_rptr),
        .o_rdata (mem_rdata)
    );

    // ---------------------------------------------------------------------
    // State registers
    // ---------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_phase     <= PH_OPCODE;
            r_op        <= '0;
            r_val       <= '0;
            r_lit_left  <= '0;
            r_bw        <= '0;
            r_wptr      <= '0;
            r_done      <= 1'b0;
            r_fill      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_phase     <= n_phase;
            r_op        <= n_op;
            r_val       <= n_val;
            r_lit_left  <= n_lit_left;
            r_bw        <= n_bw;
            r_wptr      <= n_wptr;
            r_done      <= n_done;
            r_fill      <= n_fill;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rptr      <= n_rptr;
        r_run_left  <= n_run_left;
        r_fill_byte <= n_fill_byte;
        r_bad       <= n_bad;
        r_byte      <= n_byte;
        r_last      <= n_last;
        r_lane      <= n_lane;
        r_pix       <= n_pix;
        r_cnt       <= n_cnt;
        r_run_last  <= n_run_last;
        r_finished  <= n_finished;
        r_status    <= n_status;
    end

    // ---------------------------------------------------------------------
    // Sequencer: parse one source byte, then run fills or copies one byte
    // at a time through the emit path, pushing results as lanes fill up
    // ---------------------------------------------------------------------
    assign slot_free = !r_out_valid || i_pix_ready;
    assign at_target = (r_bw >= r_target);

    // Back-copy offset check and start of the read pointer
    assign off_x   = EW'({r_byte, r_val});
    assign bw_x    = EW'(r_bw);
    assign wptr_x  = EW'(r_wptr);
    assign off_bad = (off_x == '0) || (off_x > bw_x) || (off_x > EW'(HISTORY_DEPTH));
    assign rptr_x  = (wptr_x >= off_x) ? (wptr_x - off_x)
                                       : (wptr_x + EW'(HISTORY_DEPTH) - off_x);

    // Decoding ends on a bad offset, a full output or the end of the stream
    assign fin  = r_bad || at_target || r_last;
    assign fail = r_bad || (at_target ? (r_bw != r_target) : r_last);

    always_comb begin
        n_state     = r_state;
        n_phase     = r_phase;
        n_op        = r_op;
        n_val       = r_val;
        n_lit_left  = r_lit_left;
        n_bw        = r_bw;
        n_wptr      = r_wptr;
        n_rptr      = r_rptr;
        n_run_left  = r_run_left;
        n_fill_byte = r_fill_byte;
        n_done      = r_done;
        n_bad       = r_bad;
        n_byte      = r_byte;
        n_last      = r_last;
        n_lane      = r_lane;
        n_fill      = r_fill;
        n_out_valid = r_out_valid && !i_pix_ready;
        n_pix       = r_pix;
        n_cnt       = r_cnt;
        n_run_last  = r_run_last;
        n_finished  = r_finished;
        n_status    = r_status;
        emit_en     = 1'b0;
        emit_byte   = r_fill_byte;
        mem_re      = 1'b0;

        unique case (r_state)
            ST_IDLE: begin
                if (i_src_valid) begin
                    n_byte  = i_src_byte;
                    n_last  = i_src_last;
                    n_bad   = 1'b0;
                    n_state = ST_EXEC;
                end
            end

            ST_EXEC: begin
                if (r_done) begin
                    // drop bytes after the end of decoding
                    n_state = ST_IDLE;
                end else if (at_target) begin
                    n_state = ST_FINAL;
                end else begin
                    n_state = ST_FINAL;
                    unique case (r_phase)
                        PH_OPCODE: begin
                            n_op    = r_byte;
                            n_phase = PH_VALUE;
                        end
                        PH_VALUE: begin
                            n_val   = r_byte;
                            n_phase = PH_OPCODE;
                            case (r_op)
                                OP_FILL_N: n_phase = PH_COUNT;
                                OP_LIT_N: begin
                                    n_lit_left = r_byte;
                                    if (r_byte != '0) begin
                                        n_phase = PH_LITERAL;
                                    end
                                end
                                OP_BACK:   n_phase = PH_OFFHI;
                                OP_FILL_B: n_phase = PH_FILLBYTE;
                                default: begin
                                    if (r_op[BYTE_W-1]) begin
                                        n_fill_byte = r_byte;
                                        n_run_left  = {1'b0, r_op[BYTE_W-2:0]};
                                        n_state     = ST_FILL;
                                    end else begin
                                        n_lit_left = r_op;
                                        n_phase    = PH_LITERAL;
                                    end
                                end
                            endcase
                        end
                        PH_COUNT: begin
                            n_fill_byte = r_val;
                            n_run_left  = r_byte;
                            n_phase     = PH_OPCODE;
                            n_state     = ST_FILL;
                        end
                        PH_LITERAL: begin
                            // lane buffer is empty at the start of a byte
                            emit_en    = 1'b1;
                            emit_byte  = r_byte;
                            n_lit_left = r_lit_left - 1'b1;
                            if (r_lit_left == BYTE_W'(1)) begin
                                n_phase = PH_OPCODE;
                            end
                        end
                        PH_OFFHI: begin
                            n_phase = PH_OPCODE;
                            if (off_bad) begin
                                n_bad = 1'b1;
                            end else begin
                                n_rptr     = rptr_x[AW-1:0];
                                n_run_left = r_val;
                                n_state    = ST_COPY_RD;
                            end
                        end
                        PH_FILLBYTE: begin
                            n_fill_byte = r_byte;
                            n_run_left  = r_val;
                            n_phase     = PH_OPCODE;
                            n_state     = ST_FILL;
                        end
                        default: n_phase = PH_OPCODE;
                    endcase
                end
            end

            ST_FILL: begin
                if (r_run_left == '0 || at_target) begin
                    n_state = ST_FINAL;
                end else if (r_fill == LANE_LIM) begin
                    // more bytes follow, so this result is not the last one
                    if (slot_free) begin
                        n_out_valid = 1'b1;
                        for (int i = 0; i < LANE_SLOTS; i++) begin
                            n_pix[i] = (COUNT_W'(i) < r_fill) ? r_lane[i] : '0;
                        end
                        n_cnt      = r_fill;
                        n_run_last = 1'b0;
                        n_finished = 1'b0;
                        n_status   = 1'b0;
                        n_fill     = '0;
                    end
                end else begin
                    emit_en    = 1'b1;
                    emit_byte  = r_fill_byte;
                    n_run_left = r_run_left - 1'b1;
                end
            end

            ST_COPY_RD: begin
                if (r_run_left == '0 || at_target) begin
                    n_state = ST_FINAL;
                end else if (r_fill == LANE_LIM) begin
                    if (slot_free) begin
                        n_out_valid = 1'b1;
                        for (int i = 0; i < LANE_SLOTS; i++) begin
                            n_pix[i] = (COUNT_W'(i) < r_fill) ? r_lane[i] : '0;
                        end
                        n_cnt      = r_fill;
                        n_run_last = 1'b0;
                        n_finished = 1'b0;
                        n_status   = 1'b0;
                        n_fill     = '0;
                    end
                end else begin
                    mem_re  = 1'b1;
                    n_state = ST_COPY_WR;
                end
            end

            ST_COPY_WR: begin
                emit_en    = 1'b1;
                emit_byte  = mem_rdata;
                n_run_left = r_run_left - 1'b1;
                n_rptr     = (r_rptr == PTR_LAST) ? '0 : r_rptr + 1'b1;
                n_state    = ST_COPY_RD;
            end

            ST_FINAL: begin
                if (r_fill == '0 && !fin) begin
                    n_state = ST_IDLE;
                end else if (slot_free) begin
                    // last result of this byte; an empty one marks the end
                    n_out_valid = 1'b1;
                    for (int i = 0; i < LANE_SLOTS; i++) begin
                        n_pix[i] = (COUNT_W'(i) < r_fill) ? r_lane[i] : '0;
                    end
                    n_cnt      = r_fill;
                    n_run_last = 1'b1;
                    n_finished = fin;
                    n_status   = fin && fail;
                    n_fill     = '0;
                    n_done     = fin;
                    n_state    = ST_IDLE;
                end
            end

            default: n_state = ST_IDLE;
        endcase

        // Shared emit path: history write, counters and lane buffer
        if (emit_en) begin
            n_wptr = (r_wptr == PTR_LAST) ? '0 : r_wptr + 1'b1;
            n_bw   = r_bw + 1'b1;
            n_lane[r_fill[1:0]] = emit_byte;
            n_fill = r_fill + 1'b1;
        end
    end

    // ---------------------------------------------------------------------
    // Ports
    // ---------------------------------------------------------------------
    assign o_src_ready   = (r_state == ST_IDLE);
    assign o_pix_valid   = r_out_valid;
    assign o_pixel_0     = r_pix[0];
    assign o_pixel_1     = r_pix[1];
    assign o_pixel_2     = r_pix[2];
    assign o_pixel_3     = r_pix[3];
    assign o_pixel_count = r_cnt;
    assign o_run_last    = r_run_last;
    assign o_finished    = r_finished;
    assign o_status      = r_status;

endmodule

// ----- design/rbd_checker.sv -----
// Port-level checker for the run-length back-reference decoder, with its bind.
`timescale 1ns / 1ps

module rbd_checker (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_src_valid,
    input  logic                         o_src_ready,
    input  logic                         o_pix_valid,
    input  logic                         i_pix_ready,
    input  logic [rbd_pkg::COUNT_W-1:0]  o_pixel_count,
    input  logic                         o_run_last,
    input  logic                         o_finished,
    input  logic                         o_status
);

    import rbd_pkg::*;

    // An error status only comes with the closing result
    a_status_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pix_valid && o_status) |-> o_finished)
        else $error("status set on a result that does not end decoding");

    // The closing result is always the last one of its source byte
    a_fin_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pix_valid && o_finished) |-> o_run_last)
        else $error("finished result without run_last");

    // An empty result exists only to mark the end of decoding
    a_empty_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pix_valid && (o_pixel_count == '0)) |-> o_finished)
        else $error("empty result that does not end decoding");

    // No result follows right behind the closing one
    a_fin_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pix_valid && i_pix_ready && o_finished) |=> !o_pix_valid)
        else $error("result delivered after decoding ended");

    // A taken source byte blocks the next one while it is parsed
    a_src_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_src_valid && o_src_ready) |=> !o_src_ready)
        else $error("source byte taken before the previous one was parsed");

endmodule

bind rle_backref_decompressor rbd_checker u_rbd_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_src_valid   (i_src_valid),
    .o_src_ready   (o_src_ready),
    .o_pix_valid   (o_pix_valid),
    .i_pix_ready   (i_pix_ready),
    .o_pixel_count (o_pixel_count),
    .o_run_last    (o_run_last),
    .o_finished    (o_finished),
    .o_status      (o_status)
);

// ----- tb/rle_backref_decompressor_test.sv -----
// Self-checking testbench for the run-length decoder with back references.
`timescale 1ns / 1ps

module rle_backref_decompressor_test;
    import rbd_pkg::*;

    // One decoded result as it leaves the pixel channel
    typedef struct packed {
        logic [7:0] p0;
        logic [7:0] p1;
        logic [7:0] p2;
        logic [7:0] p3;
        logic [2:0] cnt;
        logic       rl;
        logic       fin;
        logic       st;
    } pix_result_t;

    // One row of the directed stream; typed rows carry their result by hand
    typedef struct packed {
        logic [7:0]  b;
        logic        last;
        logic        typed;
        pix_result_t want;
    } src_row_t;

    // How the single decode session of the run is brought to its end
    typedef enum int {
        END_FULL,
        END_CUT,
        END_BAD_OFFSET,
        END_SHRINK
    } end_kind_t;

    localparam int HIST_DEPTH  = HISTORY_DEPTH_DEF;
    localparam int LANE_CAP    = (LANES_DEF > 4) ? 4 : LANES_DEF;
    localparam int QUIET_LIMIT = 4000;
    localparam int SQUEEZE_LEN = 400;
    localparam int PHASE_ITEMS = 25;
    localparam logic [7:0] FILL_MAX_OP = 8'hFF;   // fill 127 times with value_1

    localparam pix_result_t NO_CHECK = '0;

    function automatic pix_result_t lone_pixel(input logic [7:0] b);
        pix_result_t r;
        r = '0;
        r.p0 = b;
        r.cnt = 3'd1;
        r.rl = 1'b1;
        return r;
    endfunction

    // Directed stream: every opcode, the byte extremes and a zero fill
    // count. Decoding stays below the 1x1024 target throughout.
    localparam src_row_t DIR_TAB [0:24] = '{
        '{8'h81, 1'b0, 1'b0, NO_CHECK},          // short fill, one pixel
        '{8'hFF, 1'b0, 1'b1, lone_pixel(8'hFF)},
        '{OP_FILL_N, 1'b0, 1'b0, NO_CHECK},      // fill value 0x00 five times
        '{8'h00, 1'b0, 1'b0, NO_CHECK},
        '{8'h05, 1'b0, 1'b0, NO_CHECK},
        '{OP_LIT_N, 1'b0, 1'b0, NO_CHECK},       // three literals
        '{8'h03, 1'b0, 1'b0, NO_CHECK},
        '{8'h00, 1'b0, 1'b1, lone_pixel(8'h00)},
        '{8'hFF, 1'b0, 1'b1, lone_pixel(8'hFF)},
        '{8'hA5, 1'b0, 1'b1, lone_pixel(8'hA5)},
        '{OP_FILL_B, 1'b0, 1'b0, NO_CHECK},      // fill 0x5A six times
        '{8'h06, 1'b0, 1'b0, NO_CHECK},
        '{8'h5A, 1'b0, 1'b0, NO_CHECK},
        '{OP_BACK, 1'b0, 1'b0, NO_CHECK},        // copy 7 from 7 back
        '{8'h07, 1'b0, 1'b0, NO_CHECK},
        '{8'h00, 1'b0, 1'b0, NO_CHECK},
        '{8'h02, 1'b0, 1'b0, NO_CHECK},          // two literals, value dropped
        '{8'h33, 1'b0, 1'b0, NO_CHECK},
        '{8'h80, 1'b0, 1'b1, lone_pixel(8'h80)},
        '{8'h7F, 1'b0, 1'b1, lone_pixel(8'h7F)},
        '{FILL_MAX_OP, 1'b0, 1'b0, NO_CHECK},    // longest short fill
        '{8'hC3, 1'b0, 1'b0, NO_CHECK},
        '{OP_FILL_N, 1'b0, 1'b0, NO_CHECK},      // fill with a zero count
        '{8'h11, 1'b0, 1'b0, NO_CHECK},
        '{8'h00, 1'b0, 1'b0, NO_CHECK}
    };

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_wr_en = 1'b0;
    t_cfg_idx    cfg_index = CFG_IMAGE_WIDTH;
    logic [10:0] cfg_wdata = '0;
    logic        src_valid = 1'b0;
    logic [7:0]  src_byte = '0;
    logic        src_last = 1'b0;
    logic        pix_ready = 1'b0;

    logic        o_src_ready;
    logic        o_pix_valid;
    logic [7:0]  o_pixel_0;
    logic [7:0]  o_pixel_1;
    logic [7:0]  o_pixel_2;
    logic [7:0]  o_pixel_3;
    logic [2:0]  o_pixel_count;
    logic        o_run_last;
    logic        o_finished;
    logic        o_status;

    // Decoder mirror: parser state, output history, dimensions
    t_phase          dec_phase = PH_OPCODE;
    logic [7:0]      held_op = '0;
    logic [7:0]      held_val = '0;
    logic [7:0]      lit_left = '0;
    int unsigned     bw = 0;
    logic            dec_done = 1'b0;
    logic [10:0]     dim_w = 11'd1;
    logic [10:0]     dim_h = 11'd1;
    logic [7:0]      out_hist [HIST_DEPTH];
    logic [7:0]      lane_bytes [4];
    int              lane_n = 0;
    pix_result_t     step_out [$];

    // Results still owed by the decoder, oldest first
    pix_result_t     pixels_due [$];

    int              fault_cnt = 0;
    int              sent_cnt = 0;
    int              burst_left = 0;
    int              quiet_cycles = 0;
    logic            squeeze_go = 1'b0;

    always #4 clk = ~clk;

    rle_backref_decompressor dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_index   (cfg_index),
        .i_cfg_wdata   (cfg_wdata),
        .i_src_valid   (src_valid),
        .o_src_ready   (o_src_ready),
        .i_src_byte    (src_byte),
        .i_src_last    (src_last),
        .o_pix_valid   (o_pix_valid),
        .i_pix_ready   (pix_ready),
        .o_pixel_0     (o_pixel_0),
        .o_pixel_1     (o_pixel_1),
        .o_pixel_2     (o_pixel_2),
        .o_pixel_3     (o_pixel_3),
        .o_pixel_count (o_pixel_count),
        .o_run_last    (o_run_last),
        .o_finished    (o_finished),
        .o_status      (o_status)
    );

    function automatic int unsigned clamp_dim(input logic [10:0] v);
        if (v == 0) return 1;
        if (v > MAX_DIM_DEF) return MAX_DIM_DEF;
        return v;
    endfunction

    // Close the current result: pixels beyond the count stay zero
    task automatic push_lanes();
        pix_result_t r;
        if (lane_n == 0) return;
        r = '0;
        r.p0 = lane_bytes[0];
        if (lane_n > 1) r.p1 = lane_bytes[1];
        if (lane_n > 2) r.p2 = lane_bytes[2];
        if (lane_n > 3) r.p3 = lane_bytes[3];
        r.cnt = 3'(lane_n);
        step_out.push_back(r);
        lane_n = 0;
    endtask

    task automatic put_pixel(input logic [7:0] b);
        out_hist[bw % HIST_DEPTH] = b;
        bw++;
        lane_bytes[lane_n] = b;
        lane_n++;
        if (lane_n >= LANE_CAP) push_lanes();
    endtask

    // Emit b up to n times, cut at the output size
    task automatic repeat_pixel(input logic [7:0] b, input int unsigned n,
                                input int unsigned goal);
        for (int i = 0; i < n && bw < goal; i++) put_pixel(b);
    endtask

    // Advance the decoder mirror by one source byte; leave its results in step_out
    task automatic decode_byte(input logic [7:0] b, input logic last);
        int unsigned goal;
        int unsigned off;
        logic        fin;
        logic        bad;
        pix_result_t r;
        step_out.delete();
        if (dec_done) return;
        lane_n = 0;
        fin = 1'b0;
        bad = 1'b0;
        // size is taken anew on every byte
        goal = clamp_dim(dim_w) * clamp_dim(dim_h);
        if (bw >= goal) begin
            fin = 1'b1;
            bad = (bw != goal);
        end else begin
            case (dec_phase)
                PH_OPCODE: begin
                    held_op = b;
                    dec_phase = PH_VALUE;
                end
                PH_VALUE: begin
                    held_val = b;
                    dec_phase = PH_OPCODE;
                    if (held_op == OP_FILL_N) begin
                        dec_phase = PH_COUNT;
                    end else if (held_op == OP_LIT_N) begin
                        lit_left = b;
                        if (b != 0) dec_phase = PH_LITERAL;
                    end else if (held_op == OP_BACK) begin
                        dec_phase = PH_OFFHI;
                    end else if (held_op == OP_FILL_B) begin
                        dec_phase = PH_FILLBYTE;
                    end else if (held_op[7]) begin
                        repeat_pixel(b, held_op[6:0], goal);
                    end else begin
                        // value byte is dropped, opcode is the literal count
                        lit_left = held_op;
                        dec_phase = PH_LITERAL;
                    end
                end
                PH_COUNT: begin
                    repeat_pixel(held_val, b, goal);
                    dec_phase = PH_OPCODE;
                end
                PH_LITERAL: begin
                    put_pixel(b);
                    lit_left--;
                    if (lit_left == 0) dec_phase = PH_OPCODE;
                end
                PH_OFFHI: begin
                    off = {b, held_val};
                    dec_phase = PH_OPCODE;
                    if (off == 0 || off > bw || off > HIST_DEPTH) begin
                        fin = 1'b1;
                        bad = 1'b1;
                    end else begin
                        // overlap allowed: read what this loop just wrote
                        for (int i = 0; i < held_val && bw < goal; i++)
                            put_pixel(out_hist[(bw - off) % HIST_DEPTH]);
                    end
                end
                PH_FILLBYTE: begin
                    repeat_pixel(b, held_val, goal);
                    dec_phase = PH_OPCODE;
                end
                default: dec_phase = PH_OPCODE;
            endcase
            if (!fin) begin
                if (bw >= goal) begin
                    fin = 1'b1;
                    bad = (bw != goal);
                end else if (last) begin
                    fin = 1'b1;
                    bad = 1'b1;
                end
            end
        end
        push_lanes();
        if (fin) begin
            dec_done = 1'b1;
            // an ending byte without pixels still owes one empty result
            if (step_out.size() == 0) begin
                r = '0;
                step_out.push_back(r);
            end
            r = step_out[step_out.size() - 1];
            r.fin = 1'b1;
            r.st = bad;
            step_out[step_out.size() - 1] = r;
        end
        if (step_out.size() > 0) begin
            r = step_out[step_out.size() - 1];
            r.rl = 1'b1;
            step_out[step_out.size() - 1] = r;
        end
    endtask

    // Write both dimensions on back-to-back cycles and mirror them
    task automatic write_dims(input logic [10:0] w, input logic [10:0] h);
        cfg_wr_en <= 1'b1;
        cfg_index <= CFG_IMAGE_WIDTH;
        cfg_wdata <= w;
        @(posedge clk);
        cfg_index <= CFG_IMAGE_HEIGHT;
        cfg_wdata <= h;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        dim_w = w;
        dim_h = h;
    endtask

    // Offer one source byte in bursts with random gaps; hold it until taken,
    // then book the results it owes
    task automatic offer_byte(input logic [7:0] b, input logic last = 1'b0,
                              input logic typed = 1'b0,
                              input pix_result_t want = '0);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 20);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                src_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        src_valid <= 1'b1;
        src_byte <= b;
        src_last <= last;
        do @(posedge clk); while (!o_src_ready);
        sent_cnt++;
        decode_byte(b, last);
        if (typed) pixels_due.push_back(want);
        else foreach (step_out[i]) pixels_due.push_back(step_out[i]);
    endtask

    // Drop valid and wait until every owed result has come, then settle
    task automatic drain(input int settle);
        src_valid <= 1'b0;
        while (pixels_due.size() != 0) @(posedge clk);
        repeat (settle) @(posedge clk);
    endtask

    // One well-formed command with random content, now and then a random opcode.
    // Back copies always point inside the bytes written so far.
    task automatic gen_command();
        logic [7:0]  op;
        logic [7:0]  v;
        int unsigned pick;
        int unsigned reach;
        int unsigned off;
        int unsigned run_n;
        int unsigned n;
        pick = $urandom_range(0, 99);
        v = 8'($urandom);
        run_n = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 24);
        if (pick < 18) op = OP_FILL_N;
        else if (pick < 36) op = OP_LIT_N;
        else if (pick < 54) op = OP_BACK;
        else if (pick < 66) op = OP_FILL_B;
        else if (pick < 78) op = 8'h80 | 8'($urandom_range(1, 127));
        else if (pick < 90) op = 8'($urandom_range(1, 8));
        else begin
            op = 8'($urandom);
            // keep long literal runs and unchecked offsets out of the noise
            if (op == OP_BACK || (!op[7] && op > 8)) op[7] = 1'b1;
        end
        case (op)
            OP_BACK: begin
                reach = (bw > 65535) ? 65535 : bw;
                if ($urandom_range(0, 1) == 1)
                    off = $urandom_range(1, (reach < 16) ? reach : 16);
                else
                    off = $urandom_range(1, reach);
                offer_byte(op);
                offer_byte(8'(off));
                offer_byte(8'(off >> 8));
            end
            OP_FILL_N: begin
                offer_byte(op);
                offer_byte(v);
                offer_byte(8'(run_n));
            end
            OP_FILL_B: begin
                offer_byte(op);
                offer_byte(8'(run_n));
                offer_byte(v);
            end
            OP_LIT_N: begin
                n = $urandom_range(0, 8);
                offer_byte(op);
                offer_byte(8'(n));
                repeat (n) offer_byte(8'($urandom));
            end
            default: begin
                offer_byte(op);
                offer_byte(v);
                if (!op[7]) repeat (op) offer_byte(8'($urandom));
            end
        endcase
    endtask

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            fault_cnt++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
        end
    endtask

    // Compare each accepted result with the oldest one owed
    always @(posedge clk) begin : pixel_monitor
        pix_result_t want;
        if (rst_n && o_pix_valid && pix_ready) begin
            if (pixels_due.size() == 0) begin
                fault_cnt++;
                $display("%0t: result with nothing owed, expected none, actual count %0d",
                         $time, o_pixel_count);
            end else begin
                want = pixels_due.pop_front();
                check_field("pixel_0", want.p0, o_pixel_0);
                check_field("pixel_1", want.p1, o_pixel_1);
                check_field("pixel_2", want.p2, o_pixel_2);
                check_field("pixel_3", want.p3, o_pixel_3);
                check_field("pixel_count", want.cnt, o_pixel_count);
                check_field("run_last", want.rl, o_run_last);
                check_field("finished", want.fin, o_finished);
                check_field("status", want.st, o_status);
            end
        end
    end

    // Receiver: stretches of steady, light and heavy stalling; one long
    // hold-off when asked, so the decoder fills up and blocks its source side
    initial begin : pixel_receiver
        int  mode;
        int  span;
        logic squeezed;
        squeezed = 1'b0;
        wait (rst_n);
        forever begin
            if (squeeze_go && !squeezed) begin
                squeezed = 1'b1;
                pix_ready <= 1'b0;
                repeat (SQUEEZE_LEN) @(posedge clk);
            end
            mode = $urandom_range(0, 3);
            span = $urandom_range(8, 64);
            repeat (span) begin
                case (mode)
                    0: pix_ready <= 1'b1;
                    1: pix_ready <= 1'($urandom_range(0, 1));
                    2: pix_ready <= ($urandom_range(0, 7) != 0);
                    default: pix_ready <= ($urandom_range(0, 3) == 0);
                endcase
                @(posedge clk);
            end
        end
    end

    // Watchdog: end the run when no request moves on either channel for too long
    always @(posedge clk) begin
        if (!rst_n || (src_valid && o_src_ready) || (o_pix_valid && pix_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("rle_backref_decompressor_test NOT OK");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin : stimulus
        int unsigned w;
        int unsigned h;
        int unsigned off;
        int unsigned mark;
        int          n;
        int          cut;
        end_kind_t   ending;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part: zero width counts as 1, oversize height as 1024
        write_dims(11'd0, 11'd2047);
        foreach (DIR_TAB[k])
            offer_byte(DIR_TAB[k].b, DIR_TAB[k].last, DIR_TAB[k].typed, DIR_TAB[k].want);
        drain(20);

        // Random part in three phases; each phase gets a size well above what
        // it can write, so the session stays open. Pause and drain between them.
        for (int p = 0; p < 3; p++) begin
            if (p == 0) begin
                w = 1024;
                h = 1024;
            end else begin
                w = $urandom_range(64, 1024);
                h = (bw + 6000) / w + 1 + $urandom_range(0, 3);
                if (h > 1024) begin
                    w = 1024;
                    h = 1024;
                end
            end
            write_dims(11'(w), 11'(h));
            if (p == 1) squeeze_go = 1'b1;
            mark = sent_cnt;
            while (sent_cnt < mark + PHASE_ITEMS) gen_command();
            drain(20);
        end

        // Close the session one of four ways
        ending = end_kind_t'($urandom_range(0, 3));
        case (ending)
            END_FULL: begin
                // size just above what is written; long fills run into it
                write_dims(11'd1024, 11'(bw / 1024 + 1));
                while (!dec_done) begin
                    offer_byte(FILL_MAX_OP);
                    offer_byte(8'($urandom));
                end
            end
            END_CUT: begin
                // stream end marked on some byte of a literal command, up to its last literal
                n = $urandom_range(1, 4);
                cut = $urandom_range(0, n + 1);
                for (int k = 0; k < n + 2; k++)
                    offer_byte((k == 0) ? OP_LIT_N : ((k == 1) ? 8'(n) : 8'($urandom)),
                               k == cut);
            end
            END_BAD_OFFSET: begin
                if ($urandom_range(0, 1) == 1 || bw >= 65535) off = 0;
                else off = $urandom_range(bw + 1, 65535);
                offer_byte(OP_BACK);
                offer_byte(8'(off));
                offer_byte(8'(off >> 8));
            end
            default: begin
                // shrink below the bytes written: next byte ends with an error
                write_dims(11'd1, 11'd1);
                offer_byte(8'($urandom));
            end
        endcase

        // After the end every byte is dropped without a result
        for (int k = 0; k < 4; k++) offer_byte(8'($urandom), k == 3);
        drain(50);

        if (fault_cnt == 0 && pixels_due.size() == 0) begin
            $display("rle_backref_decompressor_test OK");
        end else begin
            $display("rle_backref_decompressor_test NOT OK");
        end
        $finish;
    end

endmodule

// ----- files.f -----
design/rbd_pkg.sv
design/rbd_ram.sv
design/rle_backref_decompressor.sv
design/rbd_checker.sv
tb/rle_backref_decompressor_test.sv
